// ===== hdl/rcm_pkg.sv =====
package rcm_pkg;

  localparam int COLUMNS_DEF = 1024;

  localparam int COL_W    = 10;
  localparam int SAMPLE_W = 32;
  localparam int COUNT_W  = 32;
  localparam int MEAN_W   = 32;
  localparam int M2_W     = 63;
  localparam int M3_W     = 64;
  localparam int M4_W     = 63;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 264;

  localparam int WIDE_W = 128;
  localparam int OPB_W  = 64;
  localparam int DIV_W  = 33;

  typedef struct packed {
    logic                    sat;
    logic [M4_W-1:0]         m4;
    logic signed [M3_W-1:0]  m3;
    logic [M2_W-1:0]         m2;
    logic signed [MEAN_W-1:0] mean;
    logic [COUNT_W-1:0]      count;
  } entry_t;

endpackage

// ===== hdl/rcm_ram.sv =====
module rcm_ram
  import rcm_pkg::*;
#(
  parameter int DEPTH = COLUMNS_DEF,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/rcm_mul.sv =====
module rcm_mul
  import rcm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WIDE_W-1:0] opa,
  input  logic [OPB_W-1:0]  opb,
  output logic              done,
  output logic [WIDE_W-1:0] product
);

  logic [WIDE_W-1:0] a_r;
  logic [OPB_W-1:0]  b_r;
  logic [3:0]        cnt;
  logic              busy;
  logic [63:0]       prod;
  logic [2:0]        sh;
  logic              prod_vld;
  logic [WIDE_W-1:0] acc;

  // one 32x32 partial product per cycle, added into the low 128 bits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      prod_vld <= 1'b0;
      cnt      <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        prod_vld <= 1'b0;
      end else if (busy) begin
        if (cnt != 4'd8) begin
          cnt      <= cnt + 4'd1;
          prod_vld <= 1'b1;
        end else begin
          prod_vld <= 1'b0;
          busy     <= 1'b0;
          done     <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= opa;
      b_r <= opb;
      acc <= '0;
    end else if (busy) begin
      if (cnt != 4'd8) begin
        prod <= a_r[32*cnt[2:1] +: 32] * b_r[32*cnt[0] +: 32];
        sh   <= {1'b0, cnt[2:1]} + {2'b0, cnt[0]};
      end
      if (prod_vld) begin
        acc <= acc + (WIDE_W'(prod) << {sh, 5'b0});
      end
    end
  end

  assign product = acc;

endmodule

// ===== hdl/rcm_div.sv =====
module rcm_div
  import rcm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WIDE_W-1:0] dividend,
  input  logic [DIV_W-1:0]  divisor,
  output logic              done,
  output logic [WIDE_W-1:0] quotient
);

  logic [WIDE_W-1:0] num;
  logic [DIV_W-1:0]  den;
  logic [DIV_W:0]    rem;
  logic [4:0]        cnt;
  logic              busy;
  logic [DIV_W:0]    rem_next;
  logic [7:0]        qbits;

  // eight restoring steps per cycle
  always_comb begin
    logic [DIV_W:0] r;
    r = rem;
    for (int i = 0; i < 8; i++) begin
      r = {r[DIV_W-1:0], num[WIDE_W-1-i]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        qbits[7-i] = 1'b1;
      end else begin
        qbits[7-i] = 1'b0;
      end
    end
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num      <= dividend;
      den      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      num      <= num << 8;
      rem      <= rem_next;
      quotient <= {quotient[WIDE_W-9:0], qbits};
    end
  end

endmodule

// ===== hdl/running_central_moments.sv =====
// Per-column running statistics (count, mean, second to fourth central moment
// sums) held in one synchronous table memory. After reset the table is swept
// to zero, one entry per cycle, before the first sample is taken. Each sample
// then runs its update: fourteen products through a shared 32x32 multiplier
// and eleven quotients by the new count through a shared divider that retires
// 8 quotient bits per cycle, one item at a time. Samples naming a column at or
// beyond COLUMNS are taken and dropped with no result. The result waits in an
// output register, so the next sample is accepted while it is still pending.
module running_central_moments
  import rcm_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // column, sample_value
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // column_out, sample_count, mean_value,
                                               // second_moment_sum, third_moment_sum,
                                               // fourth_moment_sum
  output logic [0:0]            m_axis_tuser   // saturated_flag
);

  localparam int AW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  typedef enum logic [10:0] {
    ST_CLEAR  = 11'b00000000001,
    ST_IDLE   = 11'b00000000010,
    ST_READ   = 11'b00000000100,
    ST_PREP   = 11'b00000001000,
    ST_LAUNCH = 11'b00000010000,
    ST_WAIT   = 11'b00000100000,
    ST_SUM1   = 11'b00001000000,
    ST_SUM2   = 11'b00010000000,
    ST_SUM3   = 11'b00100000000,
    ST_SUM4   = 11'b01000000000,
    ST_WRITE  = 11'b10000000000
  } state_t;

  typedef enum logic [4:0] {
    SP_QMEAN, SP_SQ, SP_CUBE, SP_QUAD,
    SP_T2_MUL, SP_T2_DIV, SP_X3_MUL, SP_X3_DIV,
    SP_T3A_MUL, SP_T3A_DIV, SP_T3B_MUL, SP_T3B_SCALE, SP_T3B_DIV,
    SP_X4_MUL, SP_X4_DIV, SP_SUB_MUL, SP_SUB_DIV1, SP_SUB_DIV2,
    SP_T4B_MUL, SP_T4B_SCALE, SP_T4B_DIV1, SP_T4B_DIV2,
    SP_T4C_MUL, SP_T4C_SCALE, SP_T4C_DIV
  } step_t;

  typedef struct packed {
    logic            sat;
    logic [M2_W-1:0] val;
  } c63_t;

  typedef struct packed {
    logic            sat;
    logic [M3_W-1:0] val;
  } c64_t;

  function automatic c63_t clamp_u63(input logic [WIDE_W-1:0] v);
    c63_t r;
    r.sat = 1'b0;
    r.val = v[M2_W-1:0];
    if (v[WIDE_W-1]) begin
      r.val = '0;
    end else if (v[WIDE_W-2:M2_W] != '0) begin
      r.sat = 1'b1;
      r.val = '1;
    end
    return r;
  endfunction

  function automatic c64_t clamp_s64(input logic [WIDE_W-1:0] v);
    c64_t r;
    r.sat = 1'b0;
    r.val = v[M3_W-1:0];
    if (!((v[WIDE_W-1:M3_W-1] == '0) || (v[WIDE_W-1:M3_W-1] == '1))) begin
      r.sat = 1'b1;
      r.val = v[WIDE_W-1] ? {1'b1, {(M3_W-1){1'b0}}} : {1'b0, {(M3_W-1){1'b1}}};
    end
    return r;
  endfunction

  state_t state;
  step_t  step;

  logic [AW-1:0]       clr_addr;
  logic [AW-1:0]       col_addr;
  logic [COL_W-1:0]    col_r;
  logic [SAMPLE_W-1:0] smp_r;
  entry_t              e;
  entry_t              ram_rdata;
  entry_t              ram_wdata;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;

  logic [COUNT_W-1:0]  n;
  logic [DIV_W-1:0]    n1;
  logic [COUNT_W-1:0]  nm1;
  logic [COUNT_W+1:0]  n3;
  logic                neg;
  logic                m3neg;
  logic [DIV_W-1:0]    a;
  logic [M3_W-1:0]     mm3;

  logic [DIV_W-1:0]    qmean;
  logic [47:0]         a2;
  logic [63:0]         a3;
  logic [79:0]         a4;
  logic [63:0]         t2;
  logic [63:0]         x3;
  logic [63:0]         t3a;
  logic [WIDE_W-1:0]   p;
  logic [WIDE_W-1:0]   t3b;
  logic [WIDE_W-1:0]   x4;
  logic [WIDE_W-1:0]   sub_r;
  logic [WIDE_W-1:0]   t4b;
  logic [WIDE_W-1:0]   t4c;
  logic [WIDE_W-1:0]   diff3;
  logic [WIDE_W-1:0]   diff4;
  logic [WIDE_W-1:0]   acc2;
  logic [WIDE_W-1:0]   acc3;
  logic [WIDE_W-1:0]   s4a;
  logic [WIDE_W-1:0]   s4b;
  logic [WIDE_W-1:0]   acc4;

  logic                is_div;
  logic [WIDE_W-1:0]   opa;
  logic [OPB_W-1:0]    opb;
  logic                mul_done;
  logic                div_done;
  logic [WIDE_W-1:0]   mul_p;
  logic [WIDE_W-1:0]   div_q;
  logic                unit_done;
  logic [WIDE_W-1:0]   res;

  logic                in_acc;
  logic                in_range;
  logic                out_free;

  logic signed [DIV_W-1:0] d_w;
  logic [DIV_W-1:0]        qmean_s;
  entry_t                  e_new;
  c63_t                    c2;
  c64_t                    c3;
  c63_t                    c4;
  logic                    cnt_max;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_range      = 32'(s_axis_tdata[COL_W-1:0]) < COLUMNS;
  assign col_addr      = AW'(s_axis_tdata[COL_W-1:0]);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  rcm_ram #(.DEPTH(COLUMNS), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (col_addr),
    .rdata (ram_rdata)
  );

  rcm_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   ((state == ST_LAUNCH) && !is_div),
    .opa     (opa),
    .opb     (opb),
    .done    (mul_done),
    .product (mul_p)
  );

  rcm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    ((state == ST_LAUNCH) && is_div),
    .dividend (opa),
    .divisor  (n1),
    .done     (div_done),
    .quotient (div_q)
  );

  assign unit_done = is_div ? div_done : mul_done;
  assign res       = is_div ? div_q : mul_p;

  // operands of each update step
  always_comb begin
    is_div = 1'b1;
    opa    = p;
    opb    = '0;
    case (step)
      SP_QMEAN: opa = WIDE_W'(a);
      SP_SQ: begin
        is_div = 1'b0;
        opa    = WIDE_W'(a);
        opb    = OPB_W'(a);
      end
      SP_CUBE: begin
        is_div = 1'b0;
        opa    = WIDE_W'(a2);
        opb    = OPB_W'(a);
      end
      SP_QUAD: begin
        is_div = 1'b0;
        opa    = WIDE_W'(a3);
        opb    = OPB_W'(a);
      end
      SP_T2_MUL: begin
        is_div = 1'b0;
        opa    = WIDE_W'(a2);
        opb    = OPB_W'(n);
      end
      SP_X3_MUL: begin
        is_div = 1'b0;
        opa    = WIDE_W'(a3);
        opb    = OPB_W'(n);
      end
      SP_T3A_MUL: begin
        is_div = 1'b0;
        opa    = WIDE_W'(x3);
        opb    = OPB_W'(nm1);
      end
      SP_T3B_MUL: begin
        is_div = 1'b0;
        opa    = WIDE_W'(e.m2);
        opb    = OPB_W'(a);
      end
      SP_T3B_SCALE: begin
        is_div = 1'b0;
        opa    = p >> 16;
        opb    = OPB_W'(3);
      end
      SP_X4_MUL: begin
        is_div = 1'b0;
        opa    = WIDE_W'(a4);
        opb    = OPB_W'(n);
      end
      SP_SUB_MUL: begin
        is_div = 1'b0;
        opa    = x4;
        opb    = OPB_W'(n3);
      end
      SP_T4B_MUL: begin
        is_div = 1'b0;
        opa    = WIDE_W'(e.m2);
        opb    = OPB_W'(a2);
      end
      SP_T4B_SCALE: begin
        is_div = 1'b0;
        opa    = p >> 16;
        opb    = OPB_W'(6);
      end
      SP_T4C_MUL: begin
        is_div = 1'b0;
        opa    = WIDE_W'(mm3);
        opb    = OPB_W'(a);
      end
      SP_T4C_SCALE: begin
        is_div = 1'b0;
        opa    = p >> 16;
        opb    = OPB_W'(4);
      end
      default: begin
        is_div = 1'b1;
        opa    = p;
      end
    endcase
  end

  // new entry
  always_comb begin
    d_w     = $signed({smp_r[SAMPLE_W-1], smp_r}) - $signed({e.mean[MEAN_W-1], e.mean});
    qmean_s = neg ? (DIV_W'(0) - qmean) : qmean;
    c2      = clamp_u63(acc2);
    c3      = clamp_s64(acc3);
    c4      = clamp_u63(acc4);
    cnt_max = (n == '1);
    e_new.count = cnt_max ? n : n1[COUNT_W-1:0];
    e_new.mean  = e.mean + qmean_s[MEAN_W-1:0];
    e_new.m2    = c2.val;
    e_new.m3    = c3.val;
    e_new.m4    = c4.val;
    e_new.sat   = e.sat | c2.sat | c3.sat | c4.sat | cnt_max;
  end

  assign ram_we    = (state == ST_CLEAR) || ((state == ST_WRITE) && out_free);
  assign ram_waddr = (state == ST_CLEAR) ? clr_addr : AW'(col_r);
  assign ram_wdata = (state == ST_CLEAR) ? '0 : e_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      step          <= SP_QMEAN;
      clr_addr      <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && !((state == ST_WRITE) && out_free)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(COLUMNS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc && in_range) begin
            state <= ST_READ;
          end
        end
        ST_READ:   state <= ST_PREP;
        ST_PREP: begin
          step  <= SP_QMEAN;
          state <= ST_LAUNCH;
        end
        ST_LAUNCH: state <= ST_WAIT;
        ST_WAIT: begin
          if (unit_done) begin
            if (step == SP_T4C_DIV) begin
              state <= ST_SUM1;
            end else begin
              step  <= step_t'(step + 5'd1);
              state <= ST_LAUNCH;
            end
          end
        end
        ST_SUM1:   state <= ST_SUM2;
        ST_SUM2:   state <= ST_SUM3;
        ST_SUM3:   state <= ST_SUM4;
        ST_SUM4:   state <= ST_WRITE;
        ST_WRITE: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        col_r <= s_axis_tdata[COL_W-1:0];
        smp_r <= s_axis_tdata[COL_W +: SAMPLE_W];
      end
      ST_READ: e <= ram_rdata;
      ST_PREP: begin
        neg   <= d_w[DIV_W-1];
        a     <= d_w[DIV_W-1] ? (DIV_W'(0) - d_w) : d_w;
        n     <= e.count;
        n1    <= DIV_W'(e.count) + DIV_W'(1);
        nm1   <= (e.count == '0) ? '0 : e.count - COUNT_W'(1);
        n3    <= (34'(e.count) << 1) + 34'(e.count);
        m3neg <= e.m3[M3_W-1];
        mm3   <= e.m3[M3_W-1] ? (M3_W'(0) - e.m3) : e.m3;
      end
      ST_WAIT: begin
        if (unit_done) begin
          p <= res;
          case (step)
            SP_QMEAN:   qmean <= res[DIV_W-1:0];
            SP_SQ:      a2    <= res[63:16];
            SP_CUBE:    a3    <= res[79:16];
            SP_QUAD:    a4    <= res[95:16];
            SP_T2_DIV:  t2    <= res[63:0];
            SP_X3_DIV:  x3    <= res[63:0];
            SP_T3A_DIV: t3a   <= res[63:0];
            SP_T3B_DIV: t3b   <= res;
            SP_X4_DIV:  x4    <= res;
            SP_SUB_DIV2: sub_r <= res;
            SP_T4B_DIV2: t4b  <= res;
            SP_T4C_DIV: t4c   <= res;
            default: ;
          endcase
        end
      end
      ST_SUM1: begin
        diff3 <= WIDE_W'(t3a) - t3b;
        diff4 <= x4 - sub_r;
        acc2  <= WIDE_W'(e.m2) + WIDE_W'(t2);
      end
      ST_SUM2: begin
        acc3 <= neg ? ({{(WIDE_W-M3_W){e.m3[M3_W-1]}}, e.m3} - diff3)
                    : ({{(WIDE_W-M3_W){e.m3[M3_W-1]}}, e.m3} + diff3);
        s4a  <= WIDE_W'(e.m4) + diff4;
      end
      ST_SUM3: s4b <= s4a + t4b;
      ST_SUM4: acc4 <= (m3neg == neg) ? (s4b - t4c) : (s4b + t4c);
      ST_WRITE: begin
        if (out_free) begin
          m_axis_tdata <= {e_new.m4, e_new.m3, e_new.m2, e_new.mean, e_new.count, col_r};
          m_axis_tuser <= e_new.sat;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== test/testbench.sv =====
module testbench;
  import rcm_pkg::*;

  localparam int FIELDS = 7;
  localparam int WATCHDOG_LIMIT = 60000;
  localparam int RANDOM_ITEMS = 1600;

  typedef struct {
    bit [31:0] count;
    bit signed [31:0] mean;
    bit [63:0] m2;
    bit signed [63:0] m3;
    bit [63:0] m4;
    bit sat;
  } col_stats_t;

  typedef struct {
    bit [OUT_DATA_W-1:0] data;
    bit sat;
  } stats_result_t;

  class moments_scoreboard;
    col_stats_t stats [COLUMNS_DEF];
    stats_result_t pending [$];
    int errors;

    function automatic bit [63:0] clamp_u63(bit [127:0] v, inout bit s);
      if (v[127]) return 0;
      if (v[126:63] != 0) begin
        s = 1;
        return 64'h7fff_ffff_ffff_ffff;
      end
      return v[63:0];
    endfunction

    function automatic bit [63:0] clamp_s64(bit [127:0] v, inout bit s);
      if (v[127:63] == '0 || v[127:63] == '1) return v[63:0];
      s = 1;
      return v[127] ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
    endfunction

    // predicts the updated entry for an accepted sample
    function automatic void note_sample(bit [COL_W-1:0] col, bit signed [31:0] smp);
      col_stats_t e;
      stats_result_t r;
      bit [127:0] n, n1, a, a2, a3, a4, m2o, mm3, x3, t3a, t3b, x4, sub, t4b, t4c, acc, p;
      bit [63:0] sq;
      bit signed [63:0] m3o;
      longint d;
      bit neg, m3neg;
      e = stats[col];
      n = 128'(e.count);
      n1 = n + 128'd1;
      m2o = 128'(e.m2);
      m3o = e.m3;
      d = longint'(smp) - longint'(e.mean);
      neg = d < 0;
      a = 128'(neg ? -d : d);
      e.mean = 32'(longint'(e.mean) + d / longint'(n1[63:0]));
      sq = a[63:0] * a[63:0];
      a2 = 128'(sq >> 16);
      p = (a2 * a) >> 16;
      a3 = 128'(p[63:0]);
      a4 = (a3 * a) >> 16;
      p = (n * a2) / n1;
      acc = m2o + 128'(p[63:0]);
      e.m2 = clamp_u63(acc, e.sat);
      p = (a3 * n) / n1;
      x3 = 128'(p[63:0]);
      p = (x3 * (n != 0 ? n - 128'd1 : 128'd0)) / n1;
      t3a = 128'(p[63:0]);
      t3b = (((m2o * a) >> 16) * 128'd3) / n1;
      acc = t3a - t3b;
      if (neg) acc = -acc;
      acc = acc + {{64{m3o[63]}}, m3o};
      e.m3 = clamp_s64(acc, e.sat);
      x4 = (a4 * n) / n1;
      sub = ((x4 * (128'd3 * n)) / n1) / n1;
      t4b = ((((m2o * a2) >> 16) * 128'd6) / n1) / n1;
      m3neg = m3o < 0;
      mm3 = {64'b0, 64'(m3neg ? -m3o : m3o)};
      t4c = (((mm3 * a) >> 16) * 128'd4) / n1;
      acc = 128'(e.m4) + (x4 - sub) + t4b;
      acc = (m3neg == neg) ? acc - t4c : acc + t4c;
      e.m4 = clamp_u63(acc, e.sat);
      if (n[31:0] == 32'hffff_ffff) e.sat = 1;
      else e.count = n1[31:0];
      stats[col] = e;
      r.data = {e.m4[62:0], e.m3, e.m2[62:0], e.mean, e.count, col};
      r.sat = e.sat;
      pending.push_back(r);
    endfunction

    function automatic void check_result(bit [OUT_DATA_W-1:0] data, bit sat);
      int lsb [FIELDS] = '{0, 10, 42, 74, 137, 201, 0};
      int wid [FIELDS] = '{10, 32, 32, 63, 64, 63, 1};
      string names [FIELDS] = '{"column_out", "sample_count", "mean_value",
                                "second_moment_sum", "third_moment_sum",
                                "fourth_moment_sum", "saturated_flag"};
      stats_result_t r;
      bit [OUT_DATA_W-1:0] mask;
      bit [63:0] ev, av;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transaction: %h", data);
        return;
      end
      r = pending.pop_front();
      for (int i = 0; i < FIELDS; i++) begin
        mask = (264'd1 << wid[i]) - 1;
        ev = (i == FIELDS - 1) ? 64'(r.sat) : 64'((r.data >> lsb[i]) & mask);
        av = (i == FIELDS - 1) ? 64'(sat) : 64'((data >> lsb[i]) & mask);
        if (ev != av) begin
          errors++;
          if (errors <= 10)
            $display("mismatch %s: expected %h actual %h", names[i], ev, av);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;

  moments_scoreboard sb;
  bit no_idle;
  int quiet_cycles;

  running_central_moments i_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // result side and watchdog
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 0;
      quiet_cycles <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser[0]);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
      m_axis_tready <= no_idle || ($urandom_range(99) >= 23);
    end
  end

  task automatic send_sample(bit [COL_W-1:0] col, bit [31:0] smp);
    s_axis_tvalid <= 1;
    s_axis_tdata <= {6'b0, smp, col};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_sample(col, smp);
    if (!no_idle && $urandom_range(99) < 23) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  task automatic send_random(int idx);
    bit [COL_W-1:0] col;
    bit [31:0] smp;
    int k;
    col = ($urandom_range(99) < 70) ? COL_W'($urandom_range(7)) : COL_W'($urandom);
    k = $urandom_range(99);
    if (k < 30) smp = $urandom;
    else if (k < 60) smp = 32'($signed($urandom_range(20000)) - 10000) << $urandom_range(16);
    else if (k < 85) smp = sb.stats[col].mean + 32'($signed($urandom_range(2000)) - 1000);
    else if (k < 92) smp = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
    else smp = $urandom_range(1) ? 32'h0 : 32'hffff_ffff;
    send_sample(col, smp);
  endtask

  initial begin
    sb = new();
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    no_idle = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    // field extremes on the first and last column
    send_sample(10'd0, 32'h0);
    send_sample(10'd1023, 32'h7fff_ffff);
    send_sample(10'd1023, 32'h8000_0000);
    send_sample(10'd0, 32'h0000_0001);
    send_sample(10'd0, 32'hffff_ffff);
    send_sample(10'd1023, 32'h0001_0000);
    // alternating extremes drive the moment sums into saturation
    for (int i = 0; i < 8; i++) send_sample(10'd5, i[0] ? 32'h8000_0000 : 32'h7fff_ffff);
    // skewed runs push the third moment both ways
    for (int i = 0; i < 5; i++) send_sample(10'd6, i == 4 ? 32'h8000_0000 : 32'h7fff_0000);
    for (int i = 0; i < 5; i++) send_sample(10'd7, i == 4 ? 32'h7fff_ffff : 32'h8000_0000);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      no_idle = (i >= 600 && i < 900);
      if (i == 1000) begin
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
      end
      send_random(i);
    end
    s_axis_tvalid <= 0;
    no_idle = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (800) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/rcm_pkg.sv
hdl/rcm_ram.sv
hdl/rcm_mul.sv
hdl/rcm_div.sv
hdl/running_central_moments.sv
test/testbench.sv
